// ===== sv/bsf_pkg.sv =====
package bsf_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned MAX_BYTES = 5;
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

    localparam logic [BYTE_W:0] FLETCHER_MOD = 9'd255;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FLAG  = 2'd0,
        CFG_END_FLAG    = 2'd1,
        CFG_ESCAPE_FLAG = 2'd2,
        CFG_ESCAPE_MASK = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic [BYTE_W-1:0] start_flag;
        logic [BYTE_W-1:0] end_flag;
        logic [BYTE_W-1:0] escape_flag;
        logic [BYTE_W-1:0] escape_mask;
    } t_cfg;

    // Line bytes for one word, slot 0 goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
        logic [BYTE_W-1:0]                sum_low;
        logic [BYTE_W-1:0]                sum_high;
    } t_expansion;

endpackage

// ===== sv/byte_stuffing_framer_fletcher.sv =====
// Byte-stuffing transmit framer with a Fletcher-16 trailer. Each input word
// is a command (start, payload byte, end) and a byte; each output word is one
// line byte with a flag marking the final byte produced for that input word.
// A word is taken into a short line buffer and its bytes leave through the
// output register at one byte per cycle while the output is not stalled. A
// start or a plain payload byte produces one line byte, an escaped payload
// byte two, an end three to five; the unused command produces nothing. The
// next word is taken in the cycle that the last byte of the previous one
// moves to the output register, giving one word per cycle on unescaped
// payload while the output is not stalled. The first byte of a word goes
// from the line buffer to the output register once the output is free.
// Configuration may change only while the framer is idle.
module byte_stuffing_framer_fletcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  bsf_pkg::t_in_word                 i_in_word,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output bsf_pkg::t_out_word                o_out_word,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_we,
    input  logic [bsf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bsf_pkg::BYTE_W-1:0]        i_cfg_data
);

    bsf_pkg::t_cfg       r_cfg;
    logic [bsf_pkg::BYTE_W-1:0] r_sum_low;
    logic [bsf_pkg::BYTE_W-1:0] r_sum_high;
    logic [bsf_pkg::MAX_BYTES-1:0][bsf_pkg::BYTE_W-1:0] r_buf;
    logic [bsf_pkg::MAX_BYTES-1:0][bsf_pkg::BYTE_W-1:0] n_buf;
    logic [bsf_pkg::CNT_W-1:0] r_buf_cnt;
    logic [bsf_pkg::CNT_W-1:0] n_buf_cnt;
    logic                r_out_valid;
    logic                n_out_valid;
    bsf_pkg::t_out_word  r_out;
    bsf_pkg::t_out_word  n_out;

    bsf_pkg::t_expansion exp_w;
    logic                out_free;
    logic                move;
    logic                last_move;
    logic                in_accept;

    bsf_expand u_expand (
        .i_cmd      (i_in_word.command),
        .i_data     (i_in_word.data_byte),
        .i_cfg      (r_cfg),
        .i_sum_low  (r_sum_low),
        .i_sum_high (r_sum_high),
        .o_exp      (exp_w)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = (r_buf_cnt != '0) && out_free;
    assign last_move  = move && (r_buf_cnt == bsf_pkg::CNT_W'(1));
    assign o_in_stall = (r_buf_cnt != '0) && !last_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_buf       = r_buf;
        n_buf_cnt   = r_buf_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (move) begin
            // Shift the buffer down one byte
            n_buf          = {bsf_pkg::BYTE_W'(0), r_buf[bsf_pkg::MAX_BYTES-1:1]};
            n_buf_cnt      = r_buf_cnt - bsf_pkg::CNT_W'(1);
            n_out.out_byte = r_buf[0];
            n_out.last     = (r_buf_cnt == bsf_pkg::CNT_W'(1));
            n_out_valid    = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (in_accept) begin
            n_buf     = exp_w.bytes;
            n_buf_cnt = exp_w.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_flag  <= 8'd2;
            r_cfg.end_flag    <= 8'd3;
            r_cfg.escape_flag <= 8'd125;
            r_cfg.escape_mask <= 8'd32;
            r_sum_low         <= '0;
            r_sum_high        <= '0;
            r_buf_cnt         <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bsf_pkg::CFG_START_FLAG:  r_cfg.start_flag  <= i_cfg_data;
                    bsf_pkg::CFG_END_FLAG:    r_cfg.end_flag    <= i_cfg_data;
                    bsf_pkg::CFG_ESCAPE_FLAG: r_cfg.escape_flag <= i_cfg_data;
                    bsf_pkg::CFG_ESCAPE_MASK: r_cfg.escape_mask <= i_cfg_data;
                    default: begin
                        r_cfg <= r_cfg;
                    end
                endcase
            end
            if (in_accept) begin
                r_sum_low  <= exp_w.sum_low;
                r_sum_high <= exp_w.sum_high;
            end
            r_buf_cnt   <= n_buf_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_out <= n_out;
    end

    // Sums are held reduced below the modulus
    a_sum_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_low != 8'hFF) && (r_sum_high != 8'hFF))
        else $error("Fletcher sum left unreduced");

    // An end clears both sums
    a_end_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_in_word.command == bsf_pkg::CMD_END)
        |=> (r_sum_low == '0) && (r_sum_high == '0))
        else $error("sums not cleared after end");

    // The last flag marks exactly the byte that empties the buffer
    a_last_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (r_out.last == ($past(r_buf_cnt) == bsf_pkg::CNT_W'(1))))
        else $error("last flag out of step with buffer");

    // A payload word always yields at least one line byte
    a_data_yields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_in_word.command == bsf_pkg::CMD_DATA)
        |=> (r_buf_cnt != '0))
        else $error("payload word produced no bytes");

endmodule

// ===== sv/bsf_expand.sv =====
module bsf_expand (
    input  logic [bsf_pkg::CMD_W-1:0]  i_cmd,
    input  logic [bsf_pkg::BYTE_W-1:0] i_data,
    input  bsf_pkg::t_cfg              i_cfg,
    input  logic [bsf_pkg::BYTE_W-1:0] i_sum_low,
    input  logic [bsf_pkg::BYTE_W-1:0] i_sum_high,
    output bsf_pkg::t_expansion        o_exp
);

    // Two byte operands sum to at most 510, so one subtract of the modulus leaves a byte
    function automatic logic [bsf_pkg::BYTE_W-1:0] add_mod(
        input logic [bsf_pkg::BYTE_W-1:0] a,
        input logic [bsf_pkg::BYTE_W-1:0] b
    );
        logic [bsf_pkg::BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= bsf_pkg::FLETCHER_MOD) begin
            s = s - bsf_pkg::FLETCHER_MOD;
        end
        return s[bsf_pkg::BYTE_W-1:0];
    endfunction

    function automatic logic is_flag(
        input logic [bsf_pkg::BYTE_W-1:0] b,
        input bsf_pkg::t_cfg              c
    );
        return (b == c.start_flag) || (b == c.end_flag) || (b == c.escape_flag);
    endfunction

    logic                        data_esc;
    logic                        hi_esc;
    logic                        lo_esc;
    logic [bsf_pkg::BYTE_W-1:0]  data_x;
    logic [bsf_pkg::BYTE_W-1:0]  low_1;
    logic [bsf_pkg::BYTE_W-1:0]  high_1;
    logic [bsf_pkg::CNT_W-1:0]   pos;

    assign data_esc = is_flag(i_data, i_cfg);
    assign hi_esc   = is_flag(i_sum_high, i_cfg);
    assign lo_esc   = is_flag(i_sum_low, i_cfg);
    assign data_x   = i_data ^ i_cfg.escape_mask;

    always_comb begin
        o_exp          = '0;
        o_exp.sum_low  = i_sum_low;
        o_exp.sum_high = i_sum_high;
        low_1          = '0;
        high_1         = '0;
        pos            = '0;
        case (i_cmd)
            bsf_pkg::CMD_START: begin
                o_exp.bytes[0] = i_cfg.start_flag;
                o_exp.count    = bsf_pkg::CNT_W'(1);
            end
            bsf_pkg::CMD_DATA: begin
                if (data_esc) begin
                    low_1          = add_mod(i_sum_low, i_cfg.escape_flag);
                    high_1         = add_mod(i_sum_high, low_1);
                    o_exp.sum_low  = add_mod(low_1, data_x);
                    o_exp.sum_high = add_mod(high_1, o_exp.sum_low);
                    o_exp.bytes[0] = i_cfg.escape_flag;
                    o_exp.bytes[1] = data_x;
                    o_exp.count    = bsf_pkg::CNT_W'(2);
                end else begin
                    o_exp.sum_low  = add_mod(i_sum_low, i_data);
                    o_exp.sum_high = add_mod(i_sum_high, o_exp.sum_low);
                    o_exp.bytes[0] = i_data;
                    o_exp.count    = bsf_pkg::CNT_W'(1);
                end
            end
            bsf_pkg::CMD_END: begin
                // Trailer: stuffed high sum, stuffed low sum, end flag
                if (hi_esc) begin
                    o_exp.bytes[0] = i_cfg.escape_flag;
                    o_exp.bytes[1] = i_sum_high ^ i_cfg.escape_mask;
                    pos            = bsf_pkg::CNT_W'(2);
                end else begin
                    o_exp.bytes[0] = i_sum_high;
                    pos            = bsf_pkg::CNT_W'(1);
                end
                if (lo_esc) begin
                    o_exp.bytes[pos]                       = i_cfg.escape_flag;
                    o_exp.bytes[pos + bsf_pkg::CNT_W'(1)]  = i_sum_low ^ i_cfg.escape_mask;
                    pos                                    = pos + bsf_pkg::CNT_W'(2);
                end else begin
                    o_exp.bytes[pos] = i_sum_low;
                    pos              = pos + bsf_pkg::CNT_W'(1);
                end
                o_exp.bytes[pos] = i_cfg.end_flag;
                o_exp.count      = pos + bsf_pkg::CNT_W'(1);
                o_exp.sum_low    = '0;
                o_exp.sum_high   = '0;
            end
            default: begin
                // Unused command: nothing out, sums kept
                o_exp.count = '0;
            end
        endcase
    end

endmodule
